// File: src/etp_pkg.sv
// shared constants, codes and control structs for the exclusive time profiler
`timescale 1ns / 1ps
`default_nettype none

package etp_pkg;

  localparam int MAX_FUNCS_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 64;

  localparam int KIND_W = 2;
  localparam int ID_W   = 6;
  localparam int TS_W   = 32;
  localparam int NF_W   = 7;

  localparam logic [NF_W-1:0] NF_RESET = 7'd64;
  localparam logic [TS_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP  = 2'd2;

  typedef struct packed {
    logic latch;
    logic err_set;
    logic push_now;
    logic top_rd;
    logic step_top;
    logic step_acc;
    logic dump_clr;
    logic dump_rd;
    logic dump_ld;
  } etp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              id_bad;
    logic              empty;
    logic              full;
    logic              dump_last;
    logic              out_free;
  } etp_status_t;

endpackage

`default_nettype wire

// File: src/etp_ifs.sv
// channel interfaces: events in, results out, configuration writes
`timescale 1ns / 1ps
`default_nettype none

interface etp_event_if import etp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   func_id;
  logic [TS_W-1:0]   timestamp;

  modport source (output valid, kind, func_id, timestamp, input ready);
  modport sink (input valid, kind, func_id, timestamp, output ready);
endinterface

interface etp_result_if import etp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] out_func_id;
  logic [TS_W-1:0] total_time;
  logic            error_seen;
  logic            last;

  modport source (output valid, out_func_id, total_time, error_seen, last, input ready);
  modport sink (input valid, out_func_id, total_time, error_seen, last, output ready);
endinterface

interface etp_cfg_if import etp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [NF_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: src/exclusive_time_profiler.sv
// top level of the exclusive time profiler: controller plus datapath
//
//  channel   role     payload                                    handshake
//  events    sink     kind, func_id, timestamp                   valid/ready
//  results   source   out_func_id, total_time, error_seen, last  valid/ready
//  cfg       sink     data (num_functions)                       valid/ready, ready always high
//
// a start or end with a frame on the stack passes through a stack read, a total read and a
// total write; a start into an empty stack, errors and unused kinds finish in the idle state
// a dump clears its index, then reads and loads each reported total in turn through the single
// totals read port, holding while the result register is not taken
// synchronous reset empties the stack, zeroes the totals through per-entry valid bits,
// clears the error flag and sets num_functions to 64
`timescale 1ns / 1ps
`default_nettype none

module exclusive_time_profiler import etp_pkg::*; #(
  parameter int MAX_FUNCS   = MAX_FUNCS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  etp_event_if.sink  events,
  etp_result_if.source results,
  etp_cfg_if.sink    cfg
);

  etp_cmd_t    cmd;
  etp_status_t status;

  assign cfg.ready = 1'b1;

  etp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (events.valid),
    .ev_ready (events.ready),
    .status   (status),
    .cmd      (cmd)
  );

  etp_datapath #(
    .MAX_FUNCS   (MAX_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ev_kind   (events.kind),
    .ev_id     (events.func_id),
    .ev_ts     (events.timestamp),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .res_ready (results.ready),
    .res_valid (results.valid),
    .res_id    (results.out_func_id),
    .res_total (results.total_time),
    .res_err   (results.error_seen),
    .res_last  (results.last),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: src/etp_ctrl.sv
// sequencing state machine for event handling and dump walks
`timescale 1ns / 1ps
`default_nettype none

module etp_ctrl import etp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        ev_valid,
  output logic             ev_ready,
  input  wire etp_status_t status,
  output etp_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TOP  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DLD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    ev_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        ev_ready = 1'b1;
        if (ev_valid) begin
          cmd.latch = 1'b1;
          case (status.kind)
            KIND_START: begin
              if (status.id_bad || status.full) begin
                cmd.err_set = 1'b1;
              end else if (status.empty) begin
                cmd.push_now = 1'b1;
              end else begin
                cmd.top_rd = 1'b1;
                state_next = S_TOP;
              end
            end
            KIND_END: begin
              if (status.id_bad || status.empty) begin
                cmd.err_set = 1'b1;
              end else begin
                cmd.top_rd = 1'b1;
                state_next = S_TOP;
              end
            end
            KIND_DUMP: begin
              cmd.dump_clr = 1'b1;
              state_next   = S_DRD;
            end
            default: ;
          endcase
        end
      end
      S_TOP: begin
        cmd.step_top = 1'b1;
        state_next   = S_ACC;
      end
      S_ACC: begin
        cmd.step_acc = 1'b1;
        state_next   = S_IDLE;
      end
      S_DRD: begin
        cmd.dump_rd = 1'b1;
        state_next  = S_DLD;
      end
      S_DLD: begin
        if (status.out_free) begin
          cmd.dump_ld = 1'b1;
          state_next  = status.dump_last ? S_IDLE : S_DRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/etp_datapath.sv
// call stack, totals memory, charge arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none

module etp_datapath import etp_pkg::*; #(
  parameter int MAX_FUNCS   = MAX_FUNCS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [KIND_W-1:0] ev_kind,
  input  wire logic [ID_W-1:0]   ev_id,
  input  wire logic [TS_W-1:0]   ev_ts,
  input  wire logic              cfg_valid,
  input  wire logic [NF_W-1:0]   cfg_data,
  input  wire logic              res_ready,
  output logic                   res_valid,
  output logic [ID_W-1:0]        res_id,
  output logic [TS_W-1:0]        res_total,
  output logic                   res_err,
  output logic                   res_last,
  input  wire etp_cmd_t          cmd,
  output etp_status_t            status
);

  localparam int FUNC_W = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  // latched event
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   id_r;
  logic [TS_W-1:0]   ts_r;

  logic [CNT_W-1:0]  count;
  logic              err;
  logic [NF_W-1:0]   nf;
  logic [FUNC_W-1:0] idx;
  logic [TS_W:0]     delta;
  logic [FUNC_W-1:0] tot_addr;

  // call stack, id and resume time kept apart so a resume can be rewritten alone
  logic [ID_W-1:0]   stk_id [STACK_DEPTH];
  logic [TS_W-1:0]   stk_rs [STACK_DEPTH];
  logic [ID_W-1:0]   stk_id_q;
  logic [TS_W-1:0]   stk_rs_q;
  logic              stk_we_id;
  logic              stk_we_rs;
  logic [SP_W-1:0]   stk_waddr;
  logic [ID_W-1:0]   stk_wid;
  logic [TS_W-1:0]   stk_wrs;
  logic [SP_W-1:0]   top_addr;

  logic [TS_W-1:0]   tot_mem [MAX_FUNCS];
  logic [MAX_FUNCS-1:0] tot_vld;
  logic [TS_W-1:0]   tot_q;
  logic              tot_q_vld;
  logic [TS_W-1:0]   tot_val;
  logic              tot_re;
  logic [FUNC_W-1:0] tot_raddr;

  logic              is_end;
  logic              ts_ge;
  logic [TS_W-1:0]   resume_next;
  logic [TS_W+1:0]   sum;
  logic [TS_W-1:0]   sum_sat;
  logic [NF_W-1:0]   n_rep;

  assign is_end   = (kind_r == KIND_END);
  assign top_addr = SP_W'(count - CNT_W'(1));

  always_comb begin
    stk_we_id = 1'b0;
    stk_we_rs = 1'b0;
    stk_waddr = count[SP_W-1:0];
    stk_wid   = ev_id;
    stk_wrs   = ev_ts;
    if (cmd.push_now) begin
      stk_we_id = 1'b1;
      stk_we_rs = 1'b1;
    end else if (cmd.step_top && !is_end) begin
      stk_we_id = 1'b1;
      stk_we_rs = 1'b1;
      stk_wid   = id_r;
      stk_wrs   = ts_r;
    end else if (cmd.step_top && is_end && count > CNT_W'(1)) begin
      // the new top resumes one tick after the end
      stk_we_rs = 1'b1;
      stk_waddr = SP_W'(count - CNT_W'(2));
      stk_wrs   = resume_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we_id) begin
      stk_id[stk_waddr] <= stk_wid;
    end
    if (stk_we_rs) begin
      stk_rs[stk_waddr] <= stk_wrs;
    end
    if (cmd.top_rd) begin
      stk_id_q <= stk_id[top_addr];
      stk_rs_q <= stk_rs[top_addr];
    end
  end

  assign tot_re    = cmd.step_top || cmd.dump_rd;
  assign tot_raddr = cmd.dump_rd ? idx :
                     (is_end ? id_r[FUNC_W-1:0] : stk_id_q[FUNC_W-1:0]);
  assign tot_val   = tot_q_vld ? tot_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.step_acc) begin
      tot_mem[tot_addr] <= sum_sat;
    end
    if (tot_re) begin
      tot_q     <= tot_mem[tot_raddr];
      tot_q_vld <= tot_vld[tot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_vld <= '0;
    end else if (cmd.step_acc) begin
      tot_vld[tot_addr] <= 1'b1;
    end
  end

  assign ts_ge       = (ts_r >= stk_rs_q);
  assign resume_next = (ts_r == TIME_MAX) ? ts_r : ts_r + TS_W'(1);
  assign sum         = {2'b00, tot_val} + {1'b0, delta};
  assign sum_sat     = (sum[TS_W+1:TS_W] != 2'b00) ? TIME_MAX : sum[TS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= ev_kind;
      id_r   <= ev_id;
      ts_r   <= ev_ts;
    end
    if (cmd.step_top) begin
      tot_addr <= tot_raddr;
      if (ts_ge) begin
        delta <= {1'b0, ts_r - stk_rs_q} + (TS_W+1)'(is_end);
      end else begin
        delta <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= 1'b0;
      nf    <= NF_RESET;
      idx   <= '0;
    end else begin
      if (cmd.push_now || (cmd.step_top && !is_end)) begin
        count <= count + CNT_W'(1);
      end else if (cmd.step_top && is_end) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.err_set) begin
        err <= 1'b1;
      end
      if (cfg_valid) begin
        nf <= cfg_data;
      end
      if (cmd.dump_clr) begin
        idx <= '0;
      end else if (cmd.dump_ld) begin
        idx <= idx + FUNC_W'(1);
      end
    end
  end

  // reported count clamps to one through the number of ids
  always_comb begin
    if (nf == '0) begin
      n_rep = NF_W'(1);
    end else if (nf > NF_W'(MAX_FUNCS)) begin
      n_rep = NF_W'(MAX_FUNCS);
    end else begin
      n_rep = nf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.dump_ld) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_ld) begin
      res_id    <= ID_W'(idx);
      res_total <= tot_val;
      res_err   <= err;
      res_last  <= status.dump_last;
    end
  end

  assign status.kind      = ev_kind;
  assign status.id_bad    = ({1'b0, ev_id} >= (ID_W+1)'(MAX_FUNCS));
  assign status.empty     = (count == '0);
  assign status.full      = (count == CNT_W'(STACK_DEPTH));
  assign status.dump_last = ((NF_W'(idx) + NF_W'(1)) == n_rep);
  assign status.out_free  = !res_valid || res_ready;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_ld |-> (!res_valid || res_ready))
    else $error("result register overwritten while held");

  a_total_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.step_acc |=> tot_vld[$past(tot_addr)])
    else $error("written total not marked valid");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err |=> err)
    else $error("error flag cleared");

endmodule

`default_nettype wire
